@@ hw/rtl/coarse_occlusion_depth_grid_macros.svh @@
// Assertion macros used by the checker file of the depth grid
`ifndef COARSE_OCCLUSION_DEPTH_GRID_MACROS_SVH
`define COARSE_OCCLUSION_DEPTH_GRID_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CODG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("codg check failed");

// Next-cycle implication, disabled while reset is asserted
`define CODG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("codg check failed");

`endif

@@ hw/rtl/codg_pkg.sv @@
// Package: shared widths, constants, command codes and sequencer states
package codg_pkg;

    localparam int GRID_WIDTH_DEF  = 512;
    localparam int GRID_HEIGHT_DEF = 256;

    localparam int CMD_W   = 2;
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int DEPTH_W = 16;

    localparam logic [DEPTH_W-1:0] EMPTY_CELL = 16'hFFFF;
    localparam logic [DEPTH_W-1:0] MAX_DEPTH  = 16'hFFFE;
    localparam logic [DEPTH_W-1:0] TOL_RESET  = 16'd655;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_RASTER = 2'd1,
        CMD_TEST   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_EVAL,
        ST_RESULT
    } t_state;

endpackage

@@ hw/rtl/codg_if.sv @@
// Interfaces: command channel, result channel and tolerance write channel

interface codg_cmd_if import codg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic               rect_valid;
    logic [X_W-1:0]     min_x;
    logic [X_W-1:0]     max_x;
    logic [Y_W-1:0]     min_y;
    logic [Y_W-1:0]     max_y;
    logic [DEPTH_W-1:0] nearest_depth;

    modport source (output valid, command, rect_valid, min_x, max_x, min_y, max_y,
                    nearest_depth, input ready);
    modport sink   (input valid, command, rect_valid, min_x, max_x, min_y, max_y,
                    nearest_depth, output ready);
endinterface

interface codg_rsp_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink   (input valid, visible, output ready);
endinterface

interface codg_cfg_if import codg_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_tolerance;

    modport source (output valid, depth_tolerance, input ready);
    modport sink   (input valid, depth_tolerance, output ready);
endinterface

@@ hw/rtl/codg_grid_ram.sv @@
// Single-port depth grid memory with registered read data
module codg_grid_ram import codg_pkg::*; #(
    parameter int CELLS = GRID_WIDTH_DEF * GRID_HEIGHT_DEF,
    parameter int AW    = $clog2(CELLS)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic               i_re,
    input  logic [AW-1:0]      i_addr,
    input  logic [DEPTH_W-1:0] i_wdata,
    output logic [DEPTH_W-1:0] o_rdata
);

    logic [DEPTH_W-1:0] r_mem [CELLS];
    logic [DEPTH_W-1:0] r_rdata;

    // Write or read one cell per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/coarse_occlusion_depth_grid.sv @@
// Top level: coarse occlusion depth grid with cell-serial sequencer
//
// The block takes one command at a time and drops ready until it is done. All work goes
// through one single-port grid memory, one cell per memory access. After reset, and for
// each clear command, a clearing pass writes every cell empty, one cell a cycle, across
// GRID_WIDTH*GRID_HEIGHT cells (131072 at the default size), with no command taken
// meanwhile. Rasterize and test visit the rectangle in row order after a setup step, each
// cell by a memory read, then a compare and optional write-back; a test stops at the
// first visible cell and ends in a result step. A rejected rectangle or an unused command
// skips the walk. Tolerance writes are always taken and apply at once, so write the
// tolerance only between commands. A finished test result waits in an output register;
// the block takes the next command while it waits, and only holds a new test result until
// the old one is taken.
module coarse_occlusion_depth_grid import codg_pkg::*; #(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    codg_cmd_if.sink    i_cmd,
    codg_rsp_if.source  o_rsp,
    codg_cfg_if.sink    i_cfg
);

    localparam int               CELLS    = GRID_WIDTH * GRID_HEIGHT;
    localparam int               AW       = $clog2(CELLS);
    localparam logic [AW-1:0]    CLR_LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0]    ROW_STEP = AW'(GRID_WIDTH);

    t_state               r_state, n_state;
    t_cmd                 r_cmd;
    logic                 r_usable;
    logic [X_W-1:0]       r_x0, r_x1, r_x;
    logic [Y_W-1:0]       r_y1, r_y;
    logic [DEPTH_W-1:0]   r_depth;
    logic [DEPTH_W-1:0]   r_tol;
    logic [AW-1:0]        r_row_addr, r_addr, r_clr_addr;
    logic                 r_vis;
    logic                 r_out_valid, r_out_vis;

    logic                 w_in_xfer;
    logic                 w_usable;
    logic [DEPTH_W-1:0]   w_depth_sat;
    logic                 w_hit, w_lower, w_x_last, w_y_last, w_last;
    logic                 w_rsp_load;
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_addr;
    logic [DEPTH_W-1:0]   ram_wdata, ram_rdata;

    // Grid storage
    codg_grid_ram #(
        .CELLS (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Qualify the incoming rectangle and saturate its depth
    assign w_in_xfer   = i_cmd.valid & i_cmd.ready;
    assign w_depth_sat = (i_cmd.nearest_depth == EMPTY_CELL) ? MAX_DEPTH : i_cmd.nearest_depth;
    assign w_usable    = i_cmd.rect_valid
                         && (i_cmd.min_x <= i_cmd.max_x)
                         && (i_cmd.min_y <= i_cmd.max_y)
                         && (32'(i_cmd.max_x) < GRID_WIDTH)
                         && (32'(i_cmd.max_y) < GRID_HEIGHT);

    // Shared compare unit: visibility test and rasterize lowering on the cell just read
    assign w_hit   = (ram_rdata == EMPTY_CELL)
                     || ({1'b0, r_depth} <= ({1'b0, ram_rdata} + {1'b0, r_tol}));
    assign w_lower = ram_rdata > r_depth;

    // Rectangle walk position
    assign w_x_last = r_x == r_x1;
    assign w_y_last = r_y == r_y1;
    assign w_last   = w_x_last && w_y_last;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CLR_LAST) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_in_xfer) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                unique case (r_cmd)
                    CMD_CLEAR:  n_state = ST_CLEAR;
                    CMD_RASTER: n_state = r_usable ? ST_READ : ST_IDLE;
                    CMD_TEST:   n_state = r_usable ? ST_READ : ST_RESULT;
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_cmd == CMD_TEST && w_hit) begin
                    n_state = ST_RESULT;
                end else if (w_last) begin
                    n_state = (r_cmd == CMD_TEST) ? ST_RESULT : ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || o_rsp.ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: memory port, command ready, result load
    always_comb begin
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = r_addr;
        ram_wdata    = r_depth;
        i_cmd.ready  = 1'b0;
        w_rsp_load   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr_addr;
                ram_wdata = EMPTY_CELL;
            end
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
            end
            ST_READ: begin
                ram_re = 1'b1;
            end
            ST_EVAL: begin
                ram_we = (r_cmd == CMD_RASTER) && w_lower;
            end
            ST_RESULT: begin
                w_rsp_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_RESET;
        end else begin
            r_state <= n_state;
            // Step the clearing pass, restart it for a clear command
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end else if (r_state == ST_SETUP) begin
                r_clr_addr <= '0;
            end
            // Hold the result until its transfer
            if (w_rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            // Take tolerance writes
            if (i_cfg.valid) begin
                r_tol <= i_cfg.depth_tolerance;
            end
        end
    end

    // Command capture and rectangle walk
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd    <= t_cmd'(i_cmd.command);
            r_usable <= w_usable;
            r_x0     <= i_cmd.min_x;
            r_x1     <= i_cmd.max_x;
            r_x      <= i_cmd.min_x;
            r_y1     <= i_cmd.max_y;
            r_y      <= i_cmd.min_y;
            r_depth  <= w_depth_sat;
        end
        if (r_state == ST_SETUP) begin
            r_row_addr <= AW'(r_y) * ROW_STEP + AW'(r_x0);
            r_addr     <= AW'(r_y) * ROW_STEP + AW'(r_x0);
            r_vis      <= 1'b1;
        end
        if (r_state == ST_EVAL) begin
            if (r_cmd == CMD_TEST && !w_hit && w_last) begin
                r_vis <= 1'b0;
            end
            // Advance along the row, or wrap to the next row
            if (w_x_last) begin
                r_x        <= r_x0;
                r_y        <= r_y + Y_W'(1);
                r_row_addr <= r_row_addr + ROW_STEP;
                r_addr     <= r_row_addr + ROW_STEP;
            end else begin
                r_x    <= r_x + X_W'(1);
                r_addr <= r_addr + AW'(1);
            end
        end
        if (w_rsp_load) begin
            r_out_vis <= r_vis;
        end
    end

    assign i_cfg.ready   = 1'b1;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.visible = r_out_vis;

endmodule

@@ hw/rtl/codg_checker.sv @@
// Port checker for the depth grid and its bind to the top level
`include "coarse_occlusion_depth_grid_macros.svh"

module codg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_visible
);

    // A command transfer starts work, so the block is busy the next cycle
    `CODG_ASSERT_NXT(a_busy_after_cmd, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // A new result only appears after the block has been busy
    `CODG_ASSERT_IMP(a_rsp_after_busy, i_clk, i_rst_n, $rose(i_out_valid), !$past(i_in_ready))

    // A stalled result stays offered
    `CODG_ASSERT_NXT(a_rsp_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // A stalled result keeps its value
    `CODG_ASSERT_NXT(a_rsp_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        $stable(i_out_visible))

endmodule

bind coarse_occlusion_depth_grid codg_checker u_codg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd.valid),
    .i_in_ready    (i_cmd.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_out_visible (o_rsp.visible)
);

@@ tb/coarse_occlusion_depth_grid_tb.sv @@
// Testbench: random and directed checks of the depth grid against an in-bench grid predictor
`timescale 1ns / 100ps

module coarse_occlusion_depth_grid_tb;
    import codg_pkg::*;

    localparam int GRID_CELLS  = GRID_WIDTH_DEF * GRID_HEIGHT_DEF;
    localparam int IDLE_PCT    = 15;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_PAUSE = 12;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int PRINT_CAP   = 40;

    // Command code the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]   command;
        logic               rect_valid;
        logic [X_W-1:0]     min_x;
        logic [X_W-1:0]     max_x;
        logic [Y_W-1:0]     min_y;
        logic [Y_W-1:0]     max_y;
        logic [DEPTH_W-1:0] depth;
    } t_grid_cmd;

    logic clk = 1'b0;
    logic rst_n;

    codg_cmd_if cmd_if ();
    codg_rsp_if rsp_if ();
    codg_cfg_if cfg_if ();

    coarse_occlusion_depth_grid i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Predictor state: grid contents and tolerance as the block should hold them
    logic [DEPTH_W-1:0] occluder_depth [GRID_CELLS];
    logic [DEPTH_W-1:0] tol_model;

    t_grid_cmd cmd_backlog[$];
    logic      visible_expected[$];
    t_grid_cmd recent_rasters[$];

    int  items_in_flight = 0;
    int  mismatch_count  = 0;
    int  cycle_count     = 0;
    int  hold_left       = 0;
    int  win_x           = 0;
    int  win_y           = 0;
    bit  cmd_taken       = 1'b0;
    bit  steady_run      = 1'b0;
    bit  hold_armed      = 1'b0;
    bit  hold_done       = 1'b0;

    always #2 clk = ~clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic void empty_grid_model();
        for (int i = 0; i < GRID_CELLS; i++)
            occluder_depth[i] = EMPTY_CELL;
    endfunction

    // Apply one command to the grid copy; a test yields its visibility verdict
    function automatic void predict_grid_command(input t_grid_cmd it, output bit yields,
                                                 output bit vis);
        logic [DEPTH_W-1:0] d;
        logic [DEPTH_W:0]   reach;
        bit                 usable;
        int                 idx;
        yields = 1'b0;
        vis    = 1'b1;
        d      = (it.depth > MAX_DEPTH) ? MAX_DEPTH : it.depth;
        usable = it.rect_valid && (it.min_x <= it.max_x) && (it.min_y <= it.max_y) &&
                 (int'(it.max_x) < GRID_WIDTH_DEF) && (int'(it.max_y) < GRID_HEIGHT_DEF);
        case (it.command)
            CMD_CLEAR: begin
                empty_grid_model();
            end
            CMD_RASTER: begin
                if (usable) begin
                    for (int y = int'(it.min_y); y <= int'(it.max_y); y++) begin
                        for (int x = int'(it.min_x); x <= int'(it.max_x); x++) begin
                            idx = y * GRID_WIDTH_DEF + x;
                            if (occluder_depth[idx] > d)
                                occluder_depth[idx] = d;
                        end
                    end
                end
            end
            CMD_TEST: begin
                yields = 1'b1;
                if (usable) begin
                    vis = 1'b0;
                    // Row-major scan, stop at the first cell that lets the rectangle show
                    for (int y = int'(it.min_y); y <= int'(it.max_y) && !vis; y++) begin
                        for (int x = int'(it.min_x); x <= int'(it.max_x) && !vis; x++) begin
                            idx   = y * GRID_WIDTH_DEF + x;
                            reach = {1'b0, occluder_depth[idx]} + {1'b0, tol_model};
                            if (occluder_depth[idx] == EMPTY_CELL || {1'b0, d} <= reach)
                                vis = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_grid_cmd make_cmd(input logic [CMD_W-1:0] command,
                                           input logic valid, input int x0, input int x1,
                                           input int y0, input int y1, input int depth);
        t_grid_cmd it;
        it.command    = command;
        it.rect_valid = valid;
        it.min_x      = X_W'(x0);
        it.max_x      = X_W'(x1);
        it.min_y      = Y_W'(y0);
        it.max_y      = Y_W'(y1);
        it.depth      = DEPTH_W'(depth);
        return it;
    endfunction

    // Rasterize command over a random rectangle, mostly inside the current hot window
    function automatic t_grid_cmd random_rect(input int w_max, input int h_max);
        int x0;
        int y0;
        int x1;
        int y1;
        if ($urandom_range(9) == 0) begin
            x0 = $urandom_range(GRID_WIDTH_DEF - 1);
            y0 = $urandom_range(GRID_HEIGHT_DEF - 1);
        end else begin
            x0 = win_x + $urandom_range(63);
            y0 = win_y + $urandom_range(31);
        end
        x1 = x0 + $urandom_range(1, w_max) - 1;
        y1 = y0 + $urandom_range(1, h_max) - 1;
        if (x1 > GRID_WIDTH_DEF - 1)
            x1 = GRID_WIDTH_DEF - 1;
        if (y1 > GRID_HEIGHT_DEF - 1)
            y1 = GRID_HEIGHT_DEF - 1;
        return make_cmd(CMD_RASTER, 1'b1, x0, x1, y0, y1, $urandom_range(65535));
    endfunction

    // Mix of occluder writes, tests aimed at recent occluders, and malformed commands
    function automatic t_grid_cmd random_command();
        t_grid_cmd it;
        t_grid_cmd src;
        int        pick;
        int        lvl;
        int        lo;
        int        hi;
        pick = $urandom_range(99);
        if (pick < 40) begin
            it = ($urandom_range(29) == 0) ? random_rect(64, 32) : random_rect(12, 8);
            recent_rasters.push_back(it);
            if (recent_rasters.size() > 8)
                void'(recent_rasters.pop_front());
        end else if (pick < 88) begin
            if (recent_rasters.size() != 0 && $urandom_range(9) < 7) begin
                src        = recent_rasters[$urandom_range(recent_rasters.size() - 1)];
                it         = src;
                it.command = CMD_TEST;
                it.min_x   = X_W'(src.min_x + $urandom_range(src.max_x - src.min_x));
                it.max_x   = X_W'(it.min_x + $urandom_range(src.max_x - it.min_x));
                it.min_y   = Y_W'(src.min_y + $urandom_range(src.max_y - src.min_y));
                it.max_y   = Y_W'(it.min_y + $urandom_range(src.max_y - it.min_y));
                // Aim the depth at the visibility threshold of the occluder
                lvl = int'((src.depth > MAX_DEPTH) ? MAX_DEPTH : src.depth) + int'(tol_model);
                if ($urandom_range(3) == 0)
                    lvl = lvl + int'($urandom_range(4000)) - 2000;
                else
                    lvl = lvl + int'($urandom_range(6)) - 3;
                if (lvl < 0)
                    lvl = 0;
                if (lvl > 65535)
                    lvl = 65535;
                it.depth = lvl[DEPTH_W-1:0];
            end else begin
                it         = random_rect(16, 8);
                it.command = CMD_TEST;
            end
        end else begin
            it         = random_rect(8, 4);
            it.command = $urandom_range(1) ? CMD_TEST : CMD_RASTER;
            case ($urandom_range(3))
                0: it.rect_valid = 1'b0;
                1: begin
                    hi       = $urandom_range(GRID_WIDTH_DEF - 2);
                    lo       = $urandom_range(GRID_WIDTH_DEF - 1, hi + 1);
                    it.max_x = X_W'(hi);
                    it.min_x = X_W'(lo);
                end
                2: begin
                    hi       = $urandom_range(GRID_HEIGHT_DEF - 2);
                    lo       = $urandom_range(GRID_HEIGHT_DEF - 1, hi + 1);
                    it.max_y = Y_W'(hi);
                    it.min_y = Y_W'(lo);
                end
                default: it.command = CMD_UNUSED;
            endcase
        end
        return it;
    endfunction

    task automatic queue_cmd(input t_grid_cmd it);
        cmd_backlog.push_back(it);
        items_in_flight++;
    endtask

    // Queue a random phase; a test closes it so its result marks the block idle
    task automatic queue_random_phase(input int count, input bit with_clear);
        t_grid_cmd it;
        win_x = $urandom_range(GRID_WIDTH_DEF - 64);
        win_y = $urandom_range(GRID_HEIGHT_DEF - 32);
        recent_rasters.delete();
        for (int n = 0; n < count; n++) begin
            if (with_clear && n == count / 2) begin
                it         = random_rect(4, 4);
                it.command = CMD_CLEAR;
                recent_rasters.delete();
            end else begin
                it = random_command();
            end
            queue_cmd(it);
        end
        do
            it = random_command();
        while (it.command != CMD_TEST);
        queue_cmd(it);
    endtask

    task automatic wait_drained();
        while (items_in_flight != 0 || visible_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [DEPTH_W-1:0] value);
        @(negedge clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.depth_tolerance <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Command driver: hold the current item until its transfer, then maybe idle
    always @(negedge clk) begin : cmd_driver
        t_grid_cmd nxt;
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (cmd_backlog.size() != 0 && (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
                nxt                  = cmd_backlog.pop_front();
                cmd_if.command       <= nxt.command;
                cmd_if.rect_valid    <= nxt.rect_valid;
                cmd_if.min_x         <= nxt.min_x;
                cmd_if.max_x         <= nxt.max_x;
                cmd_if.min_y         <= nxt.min_y;
                cmd_if.max_y         <= nxt.max_y;
                cmd_if.nearest_depth <= nxt.depth;
                cmd_if.valid         <= 1'b1;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls, one long hold-off on request
    always @(negedge clk) begin : result_ready
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    = hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_left    = HOLD_CYCLES;
            hold_done    = 1'b1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: track config and command transfers, check each result transfer
    always @(posedge clk) begin : grid_monitor
        t_grid_cmd seen;
        bit        yields;
        bit        vis;
        logic      want;
        if (!rst_n) begin
            cmd_taken = 1'b0;
        end else begin
            if (cfg_if.valid && cfg_if.ready)
                tol_model = cfg_if.depth_tolerance;
            cmd_taken = cmd_if.valid && cmd_if.ready;
            if (cmd_taken) begin
                seen.command    = cmd_if.command;
                seen.rect_valid = cmd_if.rect_valid;
                seen.min_x      = cmd_if.min_x;
                seen.max_x      = cmd_if.max_x;
                seen.min_y      = cmd_if.min_y;
                seen.max_y      = cmd_if.max_y;
                seen.depth      = cmd_if.nearest_depth;
                predict_grid_command(seen, yields, vis);
                if (yields)
                    visible_expected.push_back(vis);
                items_in_flight--;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (visible_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result visible=%b", rsp_if.visible));
                end else begin
                    want = visible_expected.pop_front();
                    if (rsp_if.visible !== want)
                        report_mismatch($sformatf("visible=%b, predicted %b",
                                                  rsp_if.visible, want));
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        rst_n                  = 1'b0;
        cmd_if.valid           = 1'b0;
        cmd_if.command         = CMD_CLEAR;
        cmd_if.rect_valid      = 1'b0;
        cmd_if.min_x           = '0;
        cmd_if.max_x           = '0;
        cmd_if.min_y           = '0;
        cmd_if.max_y           = '0;
        cmd_if.nearest_depth   = '0;
        rsp_if.ready           = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.depth_tolerance = '0;
        empty_grid_model();
        tol_model = TOL_RESET;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: row and column extremes, threshold edges, malformed rectangles
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 0, 511, 0, 255, 0));
        queue_cmd(make_cmd(CMD_RASTER, 1'b1, 0, 511, 0, 0, 1000));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 0, 511, 0, 0, 65534));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 0, 511, 0, 0, 1655));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 0, 511, 0, 0, 1656));
        queue_cmd(make_cmd(CMD_RASTER, 1'b1, 511, 511, 0, 255, 0));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 511, 511, 0, 255, 655));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 511, 511, 0, 255, 656));
        queue_cmd(make_cmd(CMD_RASTER, 1'b1, 5, 6, 10, 11, 65535));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 5, 6, 10, 11, 65535));
        queue_cmd(make_cmd(CMD_RASTER, 1'b0, 0, 511, 1, 1, 0));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 0, 511, 1, 1, 65534));
        queue_cmd(make_cmd(CMD_TEST,   1'b0, 0, 511, 0, 0, 65534));
        queue_cmd(make_cmd(CMD_RASTER, 1'b1, 10, 9, 2, 2, 0));
        queue_cmd(make_cmd(CMD_RASTER, 1'b1, 20, 21, 5, 4, 0));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 10, 9, 0, 0, 65534));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 0, 511, 1, 0, 65534));
        queue_cmd(make_cmd(CMD_UNUSED, 1'b1, 0, 511, 0, 255, 0));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 509, 511, 0, 1, 65534));
        queue_cmd(make_cmd(CMD_CLEAR,  1'b1, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 0, 511, 0, 0, 65534));
        wait_drained();

        // Zero tolerance: saturated depths against a saturated occluder
        write_tolerance(16'd0);
        queue_cmd(make_cmd(CMD_RASTER, 1'b1, 5, 6, 10, 11, 65535));
        queue_cmd(make_cmd(CMD_TEST,   1'b1, 5, 6, 10, 11, 65535));
        queue_random_phase(500, 1'b0);
        hold_armed = 1'b1;
        wait_drained();

        // Full tolerance, no idling on either side
        write_tolerance(16'hFFFF);
        steady_run = 1'b1;
        queue_random_phase(200, 1'b0);
        wait_drained();
        steady_run = 1'b0;

        write_tolerance(DEPTH_W'($urandom_range(65535)));
        queue_random_phase(500, 1'b1);
        wait_drained();

        write_tolerance(TOL_RESET);
        queue_random_phase(750, 1'b0);
        wait_drained();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
